/* rtl/core/arc_pkg.sv */
package arc_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int MIP_W = 8;
    localparam int MAC_W = 48;
    localparam int SOCK_W = 16;
    localparam int SOCK_OUT_W = 17;
    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 80;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP_MIP = 2'd1;
    localparam logic [1:0] OP_LOOKUP_MAC = 2'd2;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [MIP_W-1:0] MISS_MIP = 8'd48;
    localparam logic [SOCK_OUT_W-1:0] MISS_SOCKET = '1;

    typedef struct packed {
        logic [SOCK_W-1:0] socket;
        logic [MAC_W-1:0]  mac;
        logic [MIP_W-1:0]  mip;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

endpackage

/* rtl/core/arc_ram.sv */
module arc_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/address_resolution_cache.sv */
// Insert and any request answered at once: result valid in the cycle after the transaction.
// Lookups walk the table newest to oldest, one synchronous memory read per entry:
// a result is registered on the first hit or once the oldest entry has been read.
// One request is in flight at a time; the next is taken when the result register frees.
// Reset (rst_n low, asynchronous) empties the table by clearing the entry count;
// the table memory itself is not cleared and needs no clearing pass.
module address_resolution_cache (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // mip_addr[7:0], mac_addr[55:8], socket_id[71:56]
    input  logic [1:0]  s_tuser,  // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // mac_out[47:0], socket_out[64:48], mip_out[72:65], zero
    output logic [1:0]  m_tuser   // status[1:0]
);

    arc_pkg::state_t state_reg, state_next;
    logic [arc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [arc_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [1:0] op_reg, op_next;
    logic [arc_pkg::MIP_W-1:0] key_mip_reg, key_mip_next;
    logic [arc_pkg::MAC_W-1:0] key_mac_reg, key_mac_next;

    logic out_valid_reg, out_valid_next;
    logic [1:0] status_reg, status_next;
    logic [arc_pkg::MAC_W-1:0] mac_out_reg, mac_out_next;
    logic [arc_pkg::SOCK_OUT_W-1:0] sock_out_reg, sock_out_next;
    logic [arc_pkg::MIP_W-1:0] mip_out_reg, mip_out_next;

    logic s_fire;
    logic [1:0] in_op;
    arc_pkg::entry_t in_entry;
    arc_pkg::entry_t rd_entry;
    logic [arc_pkg::ENTRY_W-1:0] rd_data;
    logic [arc_pkg::IDX_W-1:0] rd_addr;
    logic wr_en;
    logic not_full;
    logic hit;
    logic [arc_pkg::CNT_W-1:0] count_m1;

    assign in_op = s_tuser;
    assign in_entry.mip = s_tdata[7:0];
    assign in_entry.mac = s_tdata[55:8];
    assign in_entry.socket = s_tdata[71:56];

    assign s_tready = (state_reg == arc_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign s_fire = s_tvalid && s_tready;
    assign not_full = count_reg < arc_pkg::CNT_W'(arc_pkg::TABLE_DEPTH);
    assign wr_en = s_fire && (in_op == arc_pkg::OP_INSERT) && not_full;
    assign count_m1 = count_reg - 1'b1;
    assign rd_addr = (state_reg == arc_pkg::ST_IDLE) ? count_m1[arc_pkg::IDX_W-1:0]
                                                     : idx_reg - 1'b1;
    assign rd_entry = rd_data;
    assign hit = (op_reg == arc_pkg::OP_LOOKUP_MIP) ? (rd_entry.mip == key_mip_reg)
                                                    : (rd_entry.mac == key_mac_reg);

    arc_ram #(
        .WIDTH(arc_pkg::ENTRY_W),
        .DEPTH(arc_pkg::TABLE_DEPTH),
        .ADDR_W(arc_pkg::IDX_W)
    ) u_table (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(count_reg[arc_pkg::IDX_W-1:0]),
        .wr_data(in_entry),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        op_next = op_reg;
        key_mip_next = key_mip_reg;
        key_mac_next = key_mac_reg;
        out_valid_next = out_valid_reg && !m_tready;
        status_next = status_reg;
        mac_out_next = mac_out_reg;
        sock_out_next = sock_out_reg;
        mip_out_next = mip_out_reg;
        case (state_reg)
            arc_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    op_next = in_op;
                    key_mip_next = in_entry.mip;
                    key_mac_next = in_entry.mac;
                    if (in_op == arc_pkg::OP_INSERT)
                    begin
                        out_valid_next = 1'b1;
                        status_next = not_full ? arc_pkg::STATUS_OK : arc_pkg::STATUS_FULL;
                        mac_out_next = '0;
                        sock_out_next = '0;
                        mip_out_next = '0;
                        if (not_full)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (((in_op == arc_pkg::OP_LOOKUP_MIP) ||
                              (in_op == arc_pkg::OP_LOOKUP_MAC)) &&
                             (count_reg != '0))
                    begin
                        idx_next = count_m1[arc_pkg::IDX_W-1:0];
                        state_next = arc_pkg::ST_SEARCH;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        status_next = arc_pkg::STATUS_NOT_FOUND;
                        mac_out_next = '0;
                        sock_out_next = arc_pkg::MISS_SOCKET;
                        mip_out_next = arc_pkg::MISS_MIP;
                    end
                end
            end
            arc_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    out_valid_next = 1'b1;
                    status_next = arc_pkg::STATUS_OK;
                    mac_out_next = rd_entry.mac;
                    sock_out_next = {1'b0, rd_entry.socket};
                    mip_out_next = rd_entry.mip;
                    state_next = arc_pkg::ST_IDLE;
                end
                else if (idx_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    status_next = arc_pkg::STATUS_NOT_FOUND;
                    mac_out_next = '0;
                    sock_out_next = arc_pkg::MISS_SOCKET;
                    mip_out_next = arc_pkg::MISS_MIP;
                    state_next = arc_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = arc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arc_pkg::ST_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        op_reg <= op_next;
        key_mip_reg <= key_mip_next;
        key_mac_reg <= key_mac_next;
        status_reg <= status_next;
        mac_out_reg <= mac_out_next;
        sock_out_reg <= sock_out_next;
        mip_out_reg <= mip_out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = status_reg;
    assign m_tdata = {7'b0, mip_out_reg, sock_out_reg, mac_out_reg};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= arc_pkg::CNT_W'(arc_pkg::TABLE_DEPTH))
        else $error("Entry count exceeds table depth.");

    a_no_result_while_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == arc_pkg::ST_SEARCH) |-> !out_valid_reg)
        else $error("Result pending while a search is running.");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("Accepted insert did not advance the entry count.");

    a_search_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == arc_pkg::ST_SEARCH) && (hit || (idx_reg == '0)))
        |=> (out_valid_reg && (state_reg == arc_pkg::ST_IDLE)))
        else $error("Finished search did not produce a result.");
`endif

endmodule

/* bench/address_resolution_checker.sv */
`timescale 1ns / 1ps

module address_resolution_checker
    import arc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // mip_addr[7:0], mac_addr[55:8], socket_id[71:56]
    input  logic [1:0]            s_tuser,  // operation[1:0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,  // mac_out[47:0], socket_out[64:48], mip_out[72:65]
    input  logic [1:0]            m_tuser,  // status[1:0]
    output int                    mismatches,
    output int                    replies_due,
    output int                    found_count,
    output int                    miss_count,
    output int                    full_count
);

    typedef struct packed {
        logic [1:0]            status;
        logic [MAC_W-1:0]      mac;
        logic [SOCK_OUT_W-1:0] socket;
        logic [MIP_W-1:0]      mip;
    } reply_t;

    entry_t           arp_entry [TABLE_DEPTH];
    logic [CNT_W-1:0] arp_count;
    reply_t           expected_replies [$];

    function automatic reply_t resolve_request(
        input logic [1:0]       op,
        input logic [MIP_W-1:0] mip,
        input logic [MAC_W-1:0] mac,
        input logic [SOCK_W-1:0] sock
    );
        reply_t r;
        int     i;
        logic   hit;
        r = '{status: STATUS_NOT_FOUND, mac: '0, socket: MISS_SOCKET, mip: MISS_MIP};
        hit = 1'b0;
        if (op == OP_INSERT)
        begin
            r = '{status: STATUS_OK, mac: '0, socket: '0, mip: '0};
            if (int'(arp_count) >= TABLE_DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                arp_entry[arp_count] = '{socket: sock, mac: mac, mip: mip};
                arp_count = arp_count + 1'b1;
            end
        end
        else if (op == OP_LOOKUP_MIP || op == OP_LOOKUP_MAC)
        begin
            // Newest entries are searched first so they shadow older ones.
            for (i = int'(arp_count) - 1; i >= 0 && !hit; i--)
            begin
                if (op == OP_LOOKUP_MIP ? (arp_entry[i].mip == mip) : (arp_entry[i].mac == mac))
                begin
                    hit = 1'b1;
                    r = '{status: STATUS_OK, mac: arp_entry[i].mac,
                          socket: {1'b0, arp_entry[i].socket}, mip: arp_entry[i].mip};
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        if (!rst_n)
        begin
            arp_count = '0;
            expected_replies.delete();
            replies_due = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_replies.push_back(resolve_request(s_tuser, s_tdata[7:0],
                                                           s_tdata[55:8], s_tdata[71:56]));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual status 0x%0h data 0x%0h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("status", 64'(want.status), 64'(m_tuser));
                    check_field("mac_out", 64'(want.mac), 64'(m_tdata[47:0]));
                    check_field("socket_out", 64'(want.socket), 64'(m_tdata[64:48]));
                    check_field("mip_out", 64'(want.mip), 64'(m_tdata[72:65]));
                    check_field("tdata padding", 64'd0, 64'(m_tdata[79:73]));
                    if (want.status == STATUS_OK)
                        found_count++;
                    else if (want.status == STATUS_FULL)
                        full_count++;
                    else
                        miss_count++;
                end
            end
            replies_due = expected_replies.size();
        end
    end

endmodule

/* bench/tb_address_resolution_cache.sv */
`timescale 1ns / 1ps

module tb_address_resolution_cache;
    import arc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 4;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    int mismatches;
    int replies_due;
    int found_count;
    int miss_count;
    int full_count;
    int gap_pct;
    int stall_pct;
    int cycle_count;
    int inserts_sent;
    int op_sent [4];

    logic [MIP_W-1:0] known_mips [$];
    logic [MAC_W-1:0] known_macs [$];

    address_resolution_cache uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    address_resolution_checker u_resolve_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .replies_due (replies_due),
        .found_count (found_count),
        .miss_count  (miss_count),
        .full_count  (full_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d replies outstanding.",
                     cycle_count, replies_due);
            $display("tb_address_resolution_cache: FAIL");
            $finish;
        end
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    task automatic send_req(input logic [1:0] op, input logic [MIP_W-1:0] mip,
                            input logic [MAC_W-1:0] mac, input logic [SOCK_W-1:0] sock);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {sock, mac, mip};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        op_sent[op]++;
        if (op == OP_INSERT)
        begin
            if (inserts_sent < TABLE_DEPTH)
            begin
                known_mips.push_back(mip);
                known_macs.push_back(mac);
            end
            inserts_sent++;
        end
    endtask

    task automatic send_random();
        int               pick;
        int               reuse_pct;
        logic [1:0]       op;
        logic [MIP_W-1:0] mip;
        logic [MAC_W-1:0] mac;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            op = OP_INSERT;
        else if (pick < 11)
            op = OP_UNUSED;
        else if (pick < 56)
            op = OP_LOOKUP_MIP;
        else
            op = OP_LOOKUP_MAC;
        reuse_pct = (op == OP_INSERT) ? 30 : 70;
        mip = MIP_W'($urandom_range(0, 255));
        mac = rand_mac();
        if (known_mips.size() > 0 && $urandom_range(0, 99) < reuse_pct)
            mip = known_mips[$urandom_range(0, known_mips.size() - 1)];
        if (known_macs.size() > 0 && $urandom_range(0, 99) < reuse_pct)
            mac = known_macs[$urandom_range(0, known_macs.size() - 1)];
        send_req(op, mip, mac, SOCK_W'($urandom_range(0, 65535)));
    endtask

    initial
    begin : stimulus
        int phase;
        int n;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_INSERT;
        gap_pct   = 0;
        stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_req(OP_LOOKUP_MIP, 8'h00, 48'h0, 16'h0);
        send_req(OP_LOOKUP_MAC, 8'h00, 48'h0, 16'h0);
        send_req(OP_UNUSED, 8'hFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
        send_req(OP_INSERT, 8'h00, 48'h0, 16'h0);
        send_req(OP_INSERT, 8'hFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
        send_req(OP_LOOKUP_MIP, 8'h00, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
        send_req(OP_LOOKUP_MIP, 8'hFF, 48'h0, 16'h0);
        send_req(OP_LOOKUP_MAC, 8'h00, 48'hFFFF_FFFF_FFFF, 16'h0);
        send_req(OP_LOOKUP_MAC, 8'hFF, 48'h0, 16'hFFFF);
        send_req(OP_INSERT, 8'h5A, 48'hA5A5_0000_1111, 16'h1234);
        send_req(OP_INSERT, 8'h5A, 48'h0123_4567_89AB, 16'h4321);
        send_req(OP_LOOKUP_MIP, 8'h5A, 48'h0, 16'h0);
        send_req(OP_INSERT, 8'h11, 48'h0123_4567_89AB, 16'h0007);
        send_req(OP_LOOKUP_MAC, 8'h00, 48'h0123_4567_89AB, 16'h0);
        send_req(OP_LOOKUP_MIP, 8'h77, 48'h0, 16'h0);
        send_req(OP_LOOKUP_MAC, 8'h00, 48'h1234_5678_9ABC, 16'h0);
        send_req(OP_UNUSED, 8'h00, 48'h0, 16'h0);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 73;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 73;
                end
                default:
                begin
                    gap_pct = 29;
                    stall_pct = 29;
                end
            endcase
            for (n = 0; n < RANDOM_ITEMS / 4; n++)
                send_random();
        end

        // Fill any remaining slots so the table-full rejection is always reached.
        while (inserts_sent <= TABLE_DEPTH)
            send_random();

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Requests sent: %0d inserts, %0d network lookups, %0d hardware lookups, %0d unused.",
                 op_sent[OP_INSERT], op_sent[OP_LOOKUP_MIP], op_sent[OP_LOOKUP_MAC],
                 op_sent[OP_UNUSED]);
        $display("Replies over four pacing phases: %0d ok, %0d not found, %0d table full.",
                 found_count, miss_count, full_count);
        if (mismatches == 0)
            $display("tb_address_resolution_cache: PASS");
        else
            $display("tb_address_resolution_cache: FAIL");
        $finish;
    end

endmodule
